>>> rtl/tcc_pkg.sv
package tcc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_COL,
        ESC_ROW
    } esc_t;

    localparam logic       OP_FEED      = 1'b0;
    localparam logic       OP_READ      = 1'b1;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_LOCATE  = 8'h01;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int ROW_IDX_W = 6;
    localparam int COL_IDX_W = 8;

    typedef struct packed {
        logic                 txt_we;
        logic [ROW_IDX_W-1:0] txt_row;
        logic [COL_IDX_W-1:0] txt_col;
        logic [7:0]           txt_char;
        logic                 len_we;
        logic [ROW_IDX_W-1:0] len_row;
        logic [COL_IDX_W-1:0] len_val;
        logic                 rd_en;
        logic [ROW_IDX_W-1:0] rd_row;
        logic [COL_IDX_W-1:0] rd_col;
        logic                 scroll;
    } scr_cmd_t;

endpackage

>>> rtl/tcc_screen.sv
module tcc_screen #(
    parameter int ROWS = 22,
    parameter int COLS = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tcc_pkg::scr_cmd_t                   cmd,
    input  logic [tcc_pkg::ROW_IDX_W-1:0]       lookup_row,
    output logic [tcc_pkg::COL_IDX_W-1:0]       lookup_len,
    output logic [7:0]                          rd_data
);
    import tcc_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = ROWS * (2 ** CW);
    localparam logic [RW:0]   ROWS_W = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    // Screen rows rotate over the storage; base_reg is the storage row of screen row 0.
    logic [7:0]    text_mem [DEPTH];
    logic [CW-1:0] row_len_reg [ROWS];
    logic [RW-1:0] base_reg;
    logic [RW-1:0] base_next;
    logic [RW-1:0] txt_phys;
    logic [RW-1:0] len_phys;
    logic [RW-1:0] rd_phys;
    logic [RW-1:0] look_phys;

    function automatic logic [RW-1:0] phys(input logic [RW-1:0] r, input logic [RW-1:0] b);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, b};
        if (s >= ROWS_W) begin
            s = s - ROWS_W;
        end
        return s[RW-1:0];
    endfunction

    assign txt_phys  = phys(cmd.txt_row[RW-1:0], base_reg);
    assign len_phys  = phys(cmd.len_row[RW-1:0], base_reg);
    assign rd_phys   = phys(cmd.rd_row[RW-1:0], base_reg);
    assign look_phys = phys(lookup_row[RW-1:0], base_reg);

    assign lookup_len = COL_IDX_W'(row_len_reg[look_phys]);

    always_comb begin
        base_next = base_reg;
        if (cmd.scroll) begin
            base_next = (base_reg == LAST_ROW) ? '0 : base_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            for (int i = 0; i < ROWS; i++) begin
                row_len_reg[i] <= '0;
            end
        end else begin
            base_reg <= base_next;
            if (cmd.len_we) begin
                row_len_reg[len_phys] <= cmd.len_val[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.txt_we) begin
            text_mem[{txt_phys, cmd.txt_col[CW-1:0]}] <= cmd.txt_char;
        end
        if (cmd.rd_en) begin
            rd_data <= text_mem[{rd_phys, cmd.rd_col[CW-1:0]}];
        end
    end

    a_base_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (RW + 1)'(base_reg) < ROWS_W)
        else $error("screen base row out of range");

    a_scroll_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll && base_reg == LAST_ROW |=> base_reg == '0)
        else $error("screen base did not wrap");

    a_no_scroll_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.scroll |=> $stable(base_reg))
        else $error("screen base moved without a scroll");

endmodule

>>> rtl/text_console_with_cursor_escape.sv
// Channel  Dir  tdata fields (low bit first)                         tuser
// s_       in   data_byte[7:0] read_row[12:8] read_col[18:13]        op
// m_       out  cell_char[7:0] row_length[13:8] visible_rows[18:14]  -
//               positioned[19]
// Items are accepted in the idle state; the result is loaded in the response state once
// the output register is free, and no new item is taken before the block is back in idle.
// A committing newline first passes through the commit state, which copies the pending
// line one byte per cycle out of the pending line memory into the screen.
// Reset is synchronous and clears the row lengths at once; no clearing pass is needed.
// A waiting result holds the next item in its last cycle until the output register is free.
module text_console_with_cursor_escape #(
    parameter int ROWS = 22,
    parameter int COLS = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte, read_row, read_col
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // cell_char, row_length, visible_rows, positioned
);
    import tcc_pkg::*;

    localparam int SW = $clog2(ROWS + 1);
    localparam int LW = $clog2(COLS);

    state_t state_reg, state_next;
    esc_t   esc_reg, esc_next;

    logic [7:0]           esc_col_reg, esc_col_next;
    logic [7:0]           cur_row_reg, cur_row_next;
    logic [7:0]           cur_col_reg, cur_col_next;
    logic                 positioned_reg, positioned_next;
    logic [SW-1:0]        shown_reg, shown_next;
    logic [LW-1:0]        pend_len_reg, pend_len_next;
    logic [ROW_IDX_W-1:0] cmt_row_reg, cmt_row_next;
    logic [LW-1:0]        cmt_rd_reg, cmt_rd_next;
    logic                 pv_reg, pv_next;
    logic [LW-1:0]        pcol_reg, pcol_next;
    logic                 res_hit_reg, res_hit_next;
    logic [5:0]           res_len_reg, res_len_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [23:0]          m_tdata_reg, m_tdata_next;
    logic [7:0]           pend_rd_reg;

    logic [7:0]     pend_mem [COLS];
    logic           pend_we;

    logic [7:0]           in_byte;
    logic [4:0]           in_row;
    logic [5:0]           in_col;
    logic                 accept;
    logic                 start_commit;
    logic                 commit_done;
    logic                 out_load;
    logic                 row_vis;
    scr_cmd_t             cmd;
    logic [ROW_IDX_W-1:0] lookup_row;
    logic [COL_IDX_W-1:0] lookup_len;
    logic [7:0]           rd_data;

    assign in_byte = s_tdata[7:0];
    assign in_row  = s_tdata[12:8];
    assign in_col  = s_tdata[18:13];

    assign accept       = s_tvalid && s_tready;
    assign start_commit = accept && s_tuser == OP_FEED && in_byte == CHAR_NEWLINE
                          && esc_reg == ESC_IDLE && !positioned_reg;
    assign commit_done  = state_reg == ST_COMMIT && cmt_rd_reg == pend_len_reg && !pv_reg;
    assign row_vis      = 9'(in_row) < 9'(shown_reg) && 9'(in_row) < 9'(ROWS);

    tcc_screen #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_screen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .lookup_row (lookup_row),
        .lookup_len (lookup_len),
        .rd_data    (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = start_commit ? ST_COMMIT : ST_RESP;
                end
            end
            ST_COMMIT: begin
                if (commit_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = state_reg == ST_IDLE;
        out_load = state_reg == ST_RESP && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        esc_next        = esc_reg;
        esc_col_next    = esc_col_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        positioned_next = positioned_reg;
        shown_next      = shown_reg;
        pend_len_next   = pend_len_reg;
        cmt_row_next    = cmt_row_reg;
        cmt_rd_next     = cmt_rd_reg;
        pv_next         = pv_reg;
        pcol_next       = pcol_reg;
        res_hit_next    = res_hit_reg;
        res_len_next    = res_len_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        pend_we         = 1'b0;
        cmd             = '0;
        lookup_row      = ROW_IDX_W'(cur_row_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_hit_next = 1'b0;
                    res_len_next = '0;
                    if (s_tuser == OP_READ) begin
                        lookup_row = ROW_IDX_W'(in_row);
                        if (row_vis) begin
                            res_len_next = 6'(lookup_len);
                            res_hit_next = 9'(in_col) < 9'(lookup_len);
                        end
                        cmd.rd_en  = row_vis;
                        cmd.rd_row = ROW_IDX_W'(in_row);
                        cmd.rd_col = COL_IDX_W'(in_col);
                    end else if (in_byte != CHAR_NUL) begin
                        case (esc_reg)
                            ESC_COL: begin
                                esc_col_next = in_byte - 8'd1;
                                esc_next     = ESC_ROW;
                            end
                            ESC_ROW: begin
                                cur_col_next    = esc_col_reg;
                                cur_row_next    = in_byte - 8'd1;
                                positioned_next = 1'b1;
                                esc_next        = ESC_IDLE;
                            end
                            default: begin
                                if (in_byte == CHAR_LOCATE) begin
                                    esc_next = ESC_COL;
                                end else if (in_byte == CHAR_NEWLINE) begin
                                    if (positioned_reg) begin
                                        positioned_next = 1'b0;
                                        cur_col_next    = '0;
                                    end else begin
                                        cmd.scroll   = shown_reg >= SW'(ROWS);
                                        cmt_row_next = cmd.scroll ? ROW_IDX_W'(ROWS - 1)
                                                                  : ROW_IDX_W'(shown_reg);
                                        shown_next   = cmd.scroll ? SW'(ROWS - 1) : shown_reg;
                                        cmt_rd_next  = '0;
                                        pv_next      = 1'b0;
                                    end
                                end else if (positioned_reg) begin
                                    if (9'(cur_row_reg) < 9'(ROWS)
                                            && 9'(cur_col_reg) < 9'(COLS - 1)) begin
                                        cmd.txt_we   = 1'b1;
                                        cmd.txt_row  = ROW_IDX_W'(cur_row_reg);
                                        cmd.txt_col  = cur_col_reg;
                                        cmd.txt_char = in_byte;
                                        if (lookup_len == cur_col_reg) begin
                                            cmd.len_we  = 1'b1;
                                            cmd.len_row = ROW_IDX_W'(cur_row_reg);
                                            cmd.len_val = cur_col_reg + 8'd1;
                                        end
                                        cur_col_next = cur_col_reg + 8'd1;
                                        if (9'(cur_row_reg) >= 9'(shown_reg)) begin
                                            shown_next = SW'(9'(cur_row_reg) + 9'd1);
                                        end
                                    end
                                end else if (9'(pend_len_reg) < 9'(COLS - 1)) begin
                                    pend_we       = 1'b1;
                                    pend_len_next = pend_len_reg + 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_COMMIT: begin
                if (cmt_rd_reg != pend_len_reg) begin
                    cmt_rd_next = cmt_rd_reg + 1'b1;
                    pcol_next   = cmt_rd_reg;
                    pv_next     = 1'b1;
                end else begin
                    pv_next = 1'b0;
                end
                if (pv_reg) begin
                    cmd.txt_we   = 1'b1;
                    cmd.txt_row  = cmt_row_reg;
                    cmd.txt_col  = COL_IDX_W'(pcol_reg);
                    cmd.txt_char = pend_rd_reg;
                end
                if (commit_done) begin
                    cmd.len_we    = 1'b1;
                    cmd.len_row   = cmt_row_reg;
                    cmd.len_val   = COL_IDX_W'(pend_len_reg);
                    shown_next    = shown_reg + 1'b1;
                    pend_len_next = '0;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, positioned_reg, 5'(shown_reg), res_len_reg,
                                     res_hit_reg ? rd_data : 8'd0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            esc_reg        <= ESC_IDLE;
            esc_col_reg    <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            positioned_reg <= 1'b0;
            shown_reg      <= '0;
            pend_len_reg   <= '0;
            cmt_rd_reg     <= '0;
            pv_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            esc_reg        <= esc_next;
            esc_col_reg    <= esc_col_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            positioned_reg <= positioned_next;
            shown_reg      <= shown_next;
            pend_len_reg   <= pend_len_next;
            cmt_rd_reg     <= cmt_rd_next;
            pv_reg         <= pv_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmt_row_reg <= cmt_row_next;
        pcol_reg    <= pcol_next;
        res_hit_reg <= res_hit_next;
        res_len_reg <= res_len_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_len_reg] <= in_byte;
        end
        pend_rd_reg <= pend_mem[cmt_rd_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_shown_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        shown_reg <= SW'(ROWS))
        else $error("visible row count above screen height");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        9'(pend_len_reg) <= 9'(COLS - 1))
        else $error("pending line longer than allowed");

    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMMIT |-> cmt_rd_reg <= pend_len_reg)
        else $error("line copy ran past the pending length");

    a_commit_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_done |=> state_reg == ST_RESP && pend_len_reg == '0)
        else $error("commit did not clear the pending line");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import tcc_pkg::*;

    localparam int ROWS = 22;
    localparam int COLS = 48;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] cell_char;
        logic [5:0] row_length;
        logic [4:0] visible_rows;
        logic       positioned;
    } cell_report_t;

    class console_mirror;
        logic [7:0]   screen [ROWS][COLS];
        logic [5:0]   row_len [ROWS];
        logic [7:0]   pend [COLS];
        int           shown;
        int           pend_len;
        logic         pos_mode;
        int           cur_row;
        int           cur_col;
        int           esc_col;
        esc_t         esc_state;
        cell_report_t report_q[$];
        int           fails;

        function new();
            foreach (screen[r, c]) screen[r][c] = 8'h00;
            foreach (row_len[r]) row_len[r] = 6'd0;
            foreach (pend[c]) pend[c] = 8'h00;
            shown = 0;
            pend_len = 0;
            pos_mode = 1'b0;
            cur_row = 0;
            cur_col = 0;
            esc_col = 0;
            esc_state = ESC_IDLE;
            fails = 0;
        endfunction

        function void commit_line();
            if (shown >= ROWS) begin
                for (int r = 0; r < ROWS - 1; r++) begin
                    screen[r] = screen[r + 1];
                    row_len[r] = row_len[r + 1];
                end
                shown = ROWS - 1;
            end
            for (int c = 0; c < pend_len; c++) screen[shown][c] = pend[c];
            row_len[shown] = 6'(pend_len);
            shown++;
            pend_len = 0;
        endfunction

        function void put_at_cursor(logic [7:0] b);
            if (cur_row >= ROWS || cur_col >= COLS - 1) return;
            screen[cur_row][cur_col] = b;
            if (row_len[cur_row] == cur_col) row_len[cur_row] = 6'(cur_col + 1);
            if (cur_row >= shown) shown = cur_row + 1;
            cur_col = (cur_col + 1) & 255;
        endfunction

        function void feed(logic [7:0] b);
            if (b == CHAR_NUL) return;
            if (esc_state == ESC_COL) begin
                esc_col = b - 1;
                esc_state = ESC_ROW;
                return;
            end
            if (esc_state == ESC_ROW) begin
                cur_col = esc_col;
                cur_row = b - 1;
                pos_mode = 1'b1;
                esc_state = ESC_IDLE;
                return;
            end
            if (b == CHAR_LOCATE) begin
                esc_state = ESC_COL;
            end else if (b == CHAR_NEWLINE) begin
                if (pos_mode) begin
                    pos_mode = 1'b0;
                    cur_col = 0;
                end else begin
                    commit_line();
                end
            end else if (pos_mode) begin
                put_at_cursor(b);
            end else if (pend_len < COLS - 1) begin
                pend[pend_len] = b;
                pend_len++;
            end
        endfunction

        function void note_item(logic op, logic [7:0] b, logic [4:0] r, logic [5:0] c);
            cell_report_t rep;
            rep.cell_char = 8'h00;
            rep.row_length = 6'd0;
            if (op == OP_FEED) begin
                feed(b);
            end else if (r < shown && r < ROWS) begin
                rep.row_length = row_len[r];
                if (c < row_len[r]) rep.cell_char = screen[r][c];
            end
            rep.visible_rows = 5'(shown);
            rep.positioned = pos_mode;
            report_q.push_back(rep);
        endfunction

        function void check_report(logic [23:0] d);
            cell_report_t want;
            if (report_q.size() == 0) begin
                $error("Result with no item waiting: tdata %h", d);
                fails++;
                return;
            end
            want = report_q.pop_front();
            if (d[7:0] !== want.cell_char) begin
                $error("cell_char: expected %0d, got %0d", want.cell_char, d[7:0]);
                fails++;
            end
            if (d[13:8] !== want.row_length) begin
                $error("row_length: expected %0d, got %0d", want.row_length, d[13:8]);
                fails++;
            end
            if (d[18:14] !== want.visible_rows) begin
                $error("visible_rows: expected %0d, got %0d", want.visible_rows, d[18:14]);
                fails++;
            end
            if (d[19] !== want.positioned) begin
                $error("positioned: expected %0d, got %0d", want.positioned, d[19]);
                fails++;
            end
        endfunction

        function int outstanding();
            return report_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    console_mirror mirror = new();
    int  sent = 0;
    int  cycles = 0;
    bit  idle_en = 1'b1;
    bit  rx_hold_req = 1'b0;

    always #4 aclk = ~aclk;

    text_console_with_cursor_escape #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                mirror.note_item(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[18:13]);
            if (m_tvalid && m_tready)
                mirror.check_report(m_tdata);
        end
    end

    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= !(idle_en && $urandom_range(0, 99) < 12);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b, input logic [4:0] r,
                             input logic [5:0] c);
        while (idle_en && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, c, r, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_READ || b != CHAR_NUL) sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_item(OP_FEED, b, 5'($urandom_range(0, ROWS - 1)), 6'($urandom_range(0, 63)));
    endtask

    task automatic read_cell(input int r, input int c);
        send_item(OP_READ, 8'($urandom_range(0, 255)), 5'(r), 6'(c));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mirror.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(2, 255)); while (b == CHAR_NEWLINE);
        return b;
    endfunction

    task automatic line_burst();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) n = $urandom_range(0, 12);
        else if (pick < 95) n = $urandom_range(13, COLS - 1);
        else n = $urandom_range(COLS, COLS + 12);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) put_byte(CHAR_NUL);
            put_byte(plain_char());
        end
        put_byte(CHAR_NEWLINE);
    endtask

    task automatic locate_burst();
        put_byte(CHAR_LOCATE);
        if ($urandom_range(0, 9) == 0) put_byte(CHAR_NUL);
        if ($urandom_range(0, 99) < 85) put_byte(8'($urandom_range(1, COLS)));
        else put_byte(8'($urandom_range(COLS + 1, 255)));
        if ($urandom_range(0, 99) < 80) put_byte(8'($urandom_range(1, ROWS)));
        else put_byte(8'($urandom_range(ROWS + 1, 255)));
        repeat ($urandom_range(0, 12)) put_byte(plain_char());
        if ($urandom_range(0, 99) < 70) put_byte(CHAR_NEWLINE);
    endtask

    task automatic read_burst();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 99) < 60)
                read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, 15));
            else
                read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, 63));
        end
    endtask

    initial begin
        int  pick;
        int  target;
        bit  hold_done;
        bit  pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        read_cell(0, 0);
        put_byte(CHAR_NUL);
        put_byte(8'hFF);
        put_byte(8'h41);
        put_byte(CHAR_NEWLINE);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        read_cell(ROWS - 1, 63);
        // Locate to column 2 of row 0 with a zero byte inside the sequence,
        // then write exactly at the row end.
        put_byte(CHAR_LOCATE);
        put_byte(CHAR_NUL);
        put_byte(8'd3);
        put_byte(8'd1);
        put_byte(8'h58);
        read_cell(0, 2);
        put_byte(CHAR_LOCATE);
        put_byte(8'd1);
        put_byte(8'd1);
        put_byte(8'h59);
        // A hidden row written past its end becomes visible but stays empty.
        put_byte(CHAR_LOCATE);
        put_byte(8'd41);
        put_byte(8'd6);
        put_byte(8'h5A);
        read_cell(5, 40);
        put_byte(CHAR_LOCATE);
        put_byte(8'(COLS));
        put_byte(8'd1);
        put_byte(8'h57);
        put_byte(CHAR_LOCATE);
        put_byte(8'd1);
        put_byte(8'hFF);
        put_byte(8'h51);
        put_byte(CHAR_NEWLINE);
        read_cell(0, 0);

        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            idle_en = !(sent >= target - 1200 && sent < target - 900);
            if (!hold_done && sent >= target - 1500) begin
                rx_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= target - 800) begin
                wait_drained();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) line_burst();
            else if (pick < 65) locate_burst();
            else if (pick < 90) read_burst();
            else repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mirror.fails == 0 && mirror.outstanding() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
